// ===== hw/rtl/cbl_pkg.sv =====
package cbl_pkg;

    // fixed field widths
    localparam int ODO_W       = 16;
    localparam int SONAR_W     = 8;
    localparam int MAP_W       = 16;
    localparam int RATIO_W     = 4;
    localparam int BEST_CELL_W = 4;
    localparam int BEST_PROB_W = 17;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SONAR_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LOG2  = 2'd2;

    localparam logic [MAP_W-1:0]   MAP_BITS_RST  = 16'd48234;
    localparam logic [SONAR_W-1:0] SONAR_THR_RST = 8'd25;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 4'd4;
    localparam logic [RATIO_W-1:0] RATIO_MAX     = 4'd8;

    typedef struct packed {
        logic [ODO_W-1:0]   odo_cells;
        logic [SONAR_W-1:0] sonar_distance;
    } t_in_item;

    typedef struct packed {
        logic [BEST_CELL_W-1:0] best_cell;
        logic [BEST_PROB_W-1:0] best_prob;
        logic                   block_seen;
    } t_out_item;

endpackage

// ===== hw/rtl/cbl_in_if.sv =====
interface cbl_in_if;
    import cbl_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/cbl_out_if.sv =====
interface cbl_out_if;
    import cbl_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/cbl_cmpsub.sv =====
module cbl_cmpsub #(
    parameter int W = 8
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    // shared compare and subtract, one restoring step
    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

// ===== hw/rtl/cbl_belief_mem.sv =====
module cbl_belief_mem #(
    parameter int         DEPTH = 16,
    parameter int         W     = 17,
    parameter logic [W-1:0] INIT = '0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_rdata;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // per-entry valid bits; an unwritten entry reads the initial belief
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : INIT;
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/circular_map_bayes_localizer_unit.sv =====
// Channel   Dir  Payload                                   Transfer
// i_in      in   odo_cells[16], sonar_distance[8]           valid & ready
// o_out     out  best_cell[4], best_prob[17], block_seen[1] valid & ready
// i_cfg_*   in   index[2], data[16]                         i_cfg_we
//
// One item at a time through a small sequencer around a single compare/subtract unit.
// An update walks the move, offset, sum and per-cell normalise states after its transfer,
// and ready returns only once its result leaves the emit state; the per-cell restoring
// division, one quotient bit a cycle, takes the bulk of the update.
// An item with no forward move, other than the first, is taken and gives no result.
// Synchronous active-low reset; belief cells read as the uniform value until written.
// A result holds in the output register until taken; the next item is accepted meanwhile,
// and the following result waits in the emit state while the register is still full.
module circular_map_bayes_localizer_unit #(
    parameter int MAP_CELLS      = 16,
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cbl_in_if.sink                    i_in,
    cbl_out_if.source                 o_out
);
    import cbl_pkg::*;

    localparam int IDX_W   = $clog2(MAP_CELLS);
    localparam int CELL_W  = PROB_FRAC_BITS + 1;
    localparam int SCL_W   = CELL_W + 8;
    localparam int SUM_W   = SCL_W + IDX_W;
    localparam int SU_W    = SUM_W + 1;
    localparam int STEP_W  = $clog2(PROB_FRAC_BITS + 1);
    localparam int MAPX_W  = (MAP_CELLS > MAP_W) ? MAP_CELLS : MAP_W;
    localparam int MAPX_IW = $clog2(MAPX_W);
    localparam int INIT_V  = (1 << PROB_FRAC_BITS) / MAP_CELLS;
    localparam int NEG_ADJ = (MAP_CELLS - ((1 << ODO_W) % MAP_CELLS)) % MAP_CELLS;
    localparam int RSH     = ODO_W + IDX_W;
    localparam int RECIP   = ((1 << RSH) + MAP_CELLS - 1) / MAP_CELLS;
    localparam int PROD_W  = RSH + ODO_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MOD     = 4'd1;
    localparam logic [3:0] ST_FIX     = 4'd2;
    localparam logic [3:0] ST_OFFS    = 4'd3;
    localparam logic [3:0] ST_SETUP   = 4'd4;
    localparam logic [3:0] ST_SUM_RD  = 4'd5;
    localparam logic [3:0] ST_SUM_ACC = 4'd6;
    localparam logic [3:0] ST_CHK     = 4'd7;
    localparam logic [3:0] ST_NORM_RD = 4'd8;
    localparam logic [3:0] ST_LOAD    = 4'd9;
    localparam logic [3:0] ST_DIV     = 4'd10;
    localparam logic [3:0] ST_WR      = 4'd11;
    localparam logic [3:0] ST_EMIT    = 4'd12;

    logic [3:0]         r_state;
    logic [MAP_W-1:0]   r_map_bits;
    logic [SONAR_W-1:0] r_sonar_thr;
    logic [RATIO_W-1:0] r_ratio;
    logic [ODO_W-1:0]   r_last;
    logic               r_first;
    logic [IDX_W-1:0]   r_best;
    logic [IDX_W-1:0]   r_off;

    logic [ODO_W-1:0]   r_udiff;
    logic               r_neg;
    logic               r_z;
    logic [RATIO_W-1:0] r_shift;
    logic [IDX_W-1:0]   r_amt;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_rem;
    logic [CELL_W-1:0]  r_quo;
    logic [SUM_W-1:0]   r_sum;
    logic [CELL_W-1:0]  r_maxv;
    logic [IDX_W-1:0]   r_cell;
    logic [IDX_W-1:0]   r_phys;

    logic               r_out_valid;
    t_out_item          r_out;

    logic [SU_W-1:0]    w_a;
    logic [SU_W-1:0]    w_b;
    logic               w_ge;
    logic [SU_W-1:0]    w_diff;
    logic [SU_W-1:0]    w_pick;

    logic [PROD_W-1:0]  w_prod;
    logic [ODO_W-1:0]   w_quo;
    logic [ODO_W-1:0]   w_qm;

    logic [CELL_W-1:0]  w_rdata;
    logic               w_we;
    logic [MAPX_W-1:0]  w_map_ext;
    logic               w_map_bit;
    logic [SCL_W-1:0]   w_scaled;
    logic [IDX_W-1:0]   w_phys0;
    logic [IDX_W-1:0]   w_phys_inc;
    logic               w_last_cell;
    logic               w_accept;
    logic [ODO_W-1:0]   w_in_diff;
    logic               w_trigger;
    logic               w_emit;
    logic [IDX_W+BEST_CELL_W-1:0]  w_best_ext;
    logic [CELL_W+BEST_PROB_W-1:0] w_prob_ext;

    // shared compare/subtract unit
    cbl_cmpsub #(.W(SU_W)) u_cmpsub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    // belief ring, stored at physical address (logical - offset) mod MAP_CELLS
    cbl_belief_mem #(
        .DEPTH (MAP_CELLS),
        .W     (CELL_W),
        .INIT  (CELL_W'(INIT_V))
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_phys),
        .i_wdata (r_quo),
        .i_raddr (r_phys),
        .o_rdata (w_rdata)
    );

    // move quotient by reciprocal multiplication, exact over the 16-bit count
    assign w_prod = PROD_W'(r_udiff) * PROD_W'(RECIP);
    assign w_quo  = w_prod[RSH +: ODO_W];
    assign w_qm   = w_quo * ODO_W'(MAP_CELLS);

    // operand selection for the shared unit
    always_comb begin
        w_a = '0;
        w_b = SU_W'(MAP_CELLS);
        unique case (r_state)
            ST_MOD: begin
                w_a = SU_W'(r_udiff);
                w_b = SU_W'(w_qm);
            end
            ST_FIX:  w_a = SU_W'(r_rem[IDX_W-1:0]) + (r_neg ? SU_W'(NEG_ADJ) : '0);
            ST_OFFS: w_a = SU_W'(r_amt) + SU_W'(r_off);
            ST_DIV: begin
                w_a = (r_step == '0) ? SU_W'(r_rem) : {r_rem, 1'b0};
                w_b = SU_W'(r_sum);
            end
            default: w_a = '0;
        endcase
    end

    assign w_pick = w_ge ? w_diff : w_a;

    // cell weighting
    assign w_map_ext = MAPX_W'(r_map_bits);
    assign w_map_bit = w_map_ext[MAPX_IW'(r_cell)];
    assign w_scaled  = (w_map_bit == r_z) ? (SCL_W'(w_rdata) << r_shift) : SCL_W'(w_rdata);

    // ring walk
    assign w_phys0     = (r_off == '0) ? '0 : IDX_W'(MAP_CELLS) - r_off;
    assign w_phys_inc  = (r_phys == IDX_W'(MAP_CELLS - 1)) ? '0 : r_phys + 1'b1;
    assign w_last_cell = (r_cell == IDX_W'(MAP_CELLS - 1));

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_in_diff = i_in.data.odo_cells - r_last;
    assign w_trigger = r_first || (!w_in_diff[ODO_W-1] && (w_in_diff != '0));
    assign w_we      = (r_state == ST_WR);
    assign w_emit    = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    assign w_best_ext = (IDX_W + BEST_CELL_W)'(r_best);
    assign w_prob_ext = (CELL_W + BEST_PROB_W)'(r_maxv);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bits  <= MAP_BITS_RST;
            r_sonar_thr <= SONAR_THR_RST;
            r_ratio     <= RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAP_BITS:   r_map_bits  <= i_cfg_data[MAP_W-1:0];
                REG_SONAR_THR:  r_sonar_thr <= i_cfg_data[SONAR_W-1:0];
                REG_RATIO_LOG2: r_ratio     <= i_cfg_data[RATIO_W-1:0];
                default:        r_ratio     <= r_ratio;
            endcase
        end
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_first     <= 1'b1;
            r_best      <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_trigger) begin
                        r_last  <= i_in.data.odo_cells;
                        r_first <= 1'b0;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD:     r_state <= ST_FIX;
                ST_FIX:     r_state <= ST_OFFS;
                ST_OFFS: begin
                    r_off   <= w_pick[IDX_W-1:0];
                    r_state <= ST_SETUP;
                end
                ST_SETUP:   r_state <= ST_SUM_RD;
                ST_SUM_RD:  r_state <= ST_SUM_ACC;
                ST_SUM_ACC: r_state <= w_last_cell ? ST_CHK : ST_SUM_RD;
                ST_CHK:     r_state <= (r_sum == '0) ? ST_EMIT : ST_NORM_RD;
                ST_NORM_RD: r_state <= ST_LOAD;
                ST_LOAD:    r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_step == STEP_W'(PROB_FRAC_BITS)) begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (r_quo > r_maxv) begin
                        r_best <= r_cell;
                    end
                    r_state <= w_last_cell ? ST_EMIT : ST_NORM_RD;
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_udiff <= w_in_diff;
                r_neg   <= w_in_diff[ODO_W-1];
                r_z     <= (i_in.data.sonar_distance <= r_sonar_thr);
                r_shift <= (r_ratio > RATIO_MAX) ? RATIO_MAX : r_ratio;
                r_rem   <= '0;
                r_step  <= '0;
                r_maxv  <= '0;
            end
            ST_MOD: begin
                r_rem <= SUM_W'(w_diff[IDX_W-1:0]);
            end
            ST_FIX: begin
                r_amt <= w_pick[IDX_W-1:0];
            end
            ST_SETUP: begin
                r_cell <= '0;
                r_phys <= w_phys0;
                r_sum  <= '0;
            end
            ST_SUM_ACC: begin
                r_sum  <= r_sum + SUM_W'(w_scaled);
                r_cell <= r_cell + 1'b1;
                r_phys <= w_phys_inc;
            end
            ST_CHK: begin
                r_cell <= '0;
                r_phys <= w_phys0;
            end
            ST_LOAD: begin
                r_rem  <= SUM_W'(w_scaled);
                r_quo  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_rem  <= w_pick[SUM_W-1:0];
                r_quo  <= {r_quo[CELL_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
            end
            ST_WR: begin
                if (r_quo > r_maxv) begin
                    r_maxv <= r_quo;
                end
                r_cell <= r_cell + 1'b1;
                r_phys <= w_phys_inc;
            end
            default: r_rem <= r_rem;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.best_cell  <= w_best_ext[BEST_CELL_W-1:0];
            r_out.best_prob  <= w_prob_ext[BEST_PROB_W-1:0];
            r_out.block_seen <= r_z;
        end
    end

endmodule

// ===== tb/circular_map_bayes_localizer_unit_test.sv =====
`timescale 1ns / 1ps

module circular_map_bayes_localizer_unit_test;
    import cbl_pkg::*;

    localparam int RING_CELLS       = 16;
    localparam int FRAC_BITS        = 16;
    localparam int SETTLE_CYCLES    = 400;   // a little over one full update
    localparam int RANDOM_PER_PHASE = 272;
    localparam int PHASES           = 6;
    localparam longint LIMIT_NS     = 100_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cbl_in_if  in_if ();
    cbl_out_if out_if ();

    circular_map_bayes_localizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state and its copy of the registers
    logic [BEST_PROB_W-1:0] ring_prob [RING_CELLS];
    logic [ODO_W-1:0]       ring_last_count;
    bit                     ring_first_pending;
    logic [BEST_CELL_W-1:0] ring_peak_idx;
    logic [MAP_W-1:0]       cfg_map;
    logic [SONAR_W-1:0]     cfg_thr;
    logic [RATIO_W-1:0]     cfg_ratio;

    t_in_item  pending_items [$];
    t_out_item awaited_results [$];

    int  items_sent  = 0;
    int  items_taken = 0;
    int  mismatches  = 0;
    bit  in_taken    = 1'b0;
    int  send_idle_pct = 26;
    int  recv_idle_pct = 62;
    logic [ODO_W-1:0] walk_count = '0;

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("circular_map_bayes_localizer_unit_test: FAIL");
        $finish;
    end

    function automatic void reset_localizer();
        for (int i = 0; i < RING_CELLS; i++) begin
            ring_prob[i] = BEST_PROB_W'((1 << FRAC_BITS) / RING_CELLS);
        end
        ring_last_count    = '0;
        ring_first_pending = 1'b1;
        ring_peak_idx      = '0;
        cfg_map            = MAP_BITS_RST;
        cfg_thr            = SONAR_THR_RST;
        cfg_ratio          = RATIO_RST;
    endfunction

    // one measurement update; returns 1 when the item gives a result
    function automatic bit localize_step(input t_in_item it, output t_out_item res);
        logic [ODO_W-1:0] step;
        logic [63:0]      work [RING_CELLS];
        logic [63:0]      total;
        logic [63:0]      top;
        logic             seen;
        int               rot;
        int               shift;
        res  = '0;
        step = it.odo_cells - ring_last_count;
        if (!ring_first_pending && (step == '0 || step[ODO_W-1])) begin
            return 1'b0;
        end
        ring_last_count    = it.odo_cells;
        ring_first_pending = 1'b0;

        // rotate right by the move modulo the ring size
        rot = int'(step[3:0]);
        for (int i = 0; i < RING_CELLS; i++) begin
            work[(i + rot) % RING_CELLS] = 64'(ring_prob[i]);
        end

        // weight cells that agree with the measurement
        seen  = (it.sonar_distance <= cfg_thr);
        shift = (cfg_ratio > RATIO_MAX) ? int'(RATIO_MAX) : int'(cfg_ratio);
        for (int i = 0; i < RING_CELLS; i++) begin
            if (cfg_map[i] == seen) begin
                work[i] = work[i] << shift;
            end
        end

        // renormalise, leaving a zero ring alone
        total = '0;
        for (int i = 0; i < RING_CELLS; i++) begin
            total += work[i];
        end
        if (total != 0) begin
            for (int i = 0; i < RING_CELLS; i++) begin
                work[i] = (work[i] << FRAC_BITS) / total;
            end
        end

        // first maximum; an all-zero ring keeps the old index
        top = '0;
        for (int i = 0; i < RING_CELLS; i++) begin
            if (work[i] > top) begin
                top           = work[i];
                ring_peak_idx = BEST_CELL_W'(i);
            end
            ring_prob[i] = work[i][BEST_PROB_W-1:0];
        end

        res.best_cell  = ring_peak_idx;
        res.best_prob  = ring_prob[ring_peak_idx];
        res.block_seen = seen;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // input driver: new item only once the previous one has transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.valid <= 1'b1;
                in_if.data  <= pending_items.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results, then predict for each accepted item
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_out_item pred;
        if (out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result cell=%0d prob=%0d seen=%0b",
                                          got.best_cell, got.best_prob, got.block_seen));
            end else begin
                want = awaited_results.pop_front();
                if (got.best_cell !== want.best_cell)
                    report_mismatch($sformatf("best_cell got %0d want %0d",
                                              got.best_cell, want.best_cell));
                if (got.best_prob !== want.best_prob)
                    report_mismatch($sformatf("best_prob got %0d want %0d",
                                              got.best_prob, want.best_prob));
                if (got.block_seen !== want.block_seen)
                    report_mismatch($sformatf("block_seen got %0b want %0b",
                                              got.block_seen, want.block_seen));
            end
        end
        in_taken = in_if.valid && in_if.ready;
        if (in_taken) begin
            items_taken++;
            if (localize_step(in_if.data, pred)) begin
                awaited_results.push_back(pred);
            end
        end
    end

    task automatic push_item(input logic [ODO_W-1:0] odo, input logic [SONAR_W-1:0] sonar);
        t_in_item it;
        it.odo_cells      = odo;
        it.sonar_distance = sonar;
        pending_items.push_back(it);
        items_sent++;
    endtask

    // mostly forward moves, with stand-stills, reversals and wild counts mixed in
    task automatic push_random_items(input int n);
        int kind;
        int near;
        logic [ODO_W-1:0]   odo;
        logic [SONAR_W-1:0] sonar;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(99);
            if (kind < 5) begin
                walk_count += ODO_W'($urandom_range(1, 32767));
                odo = walk_count;
            end else if (kind < 70) begin
                walk_count += ODO_W'($urandom_range(1, 20));
                odo = walk_count;
            end else if (kind < 80) begin
                odo = walk_count;
            end else if (kind < 90) begin
                odo = walk_count - ODO_W'($urandom_range(1, 300));
            end else begin
                odo = ODO_W'($urandom_range(0, 65535));
            end

            kind = $urandom_range(99);
            if (kind < 40) begin
                sonar = SONAR_W'($urandom_range(0, 255));
            end else if (kind < 80) begin
                near = int'(cfg_thr) + int'($urandom_range(0, 6)) - 3;
                if (near < 0) near = 0;
                if (near > 255) near = 255;
                sonar = SONAR_W'(near);
            end else begin
                sonar = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            end
            push_item(odo, sonar);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_MAP_BITS:   cfg_map   = val[MAP_W-1:0];
            REG_SONAR_THR:  cfg_thr   = val[SONAR_W-1:0];
            REG_RATIO_LOG2: cfg_ratio = val[RATIO_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // all transfers done and every result back, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (!(items_taken == items_sent && awaited_results.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // main sequence
    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        reset_localizer();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset settings
        @(posedge i_clk);
        push_item(16'hFFF3, 8'd0);     // first item, negative difference
        push_item(16'hFFF3, 8'd255);   // no movement
        push_item(16'hFFF0, 8'd10);    // backwards
        push_item(16'hFFF4, 8'd25);    // one cell, sonar at threshold
        push_item(16'h0003, 8'd26);    // fifteen cells across the wrap, just above threshold
        push_item(16'h0013, 8'd255);   // a full turn
        push_item(16'h0024, 8'd0);     // seventeen cells
        push_item(16'h8023, 8'd24);    // largest forward step
        push_item(16'h0023, 8'd200);   // half-range step reads as negative
        push_item(16'hFFFF, 8'd128);
        push_item(16'h0000, 8'd1);     // wrap by one
        push_item(16'h0000, 8'd0);
        push_item(16'h0005, 8'hAA);
        push_item(16'h0006, 8'h55);
        for (int k = 0; k < 6; k++) begin
            push_item(16'h0007 + 16'(k), 8'd0);
        end
        walk_count = 16'h000C;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MAP_BITS,   16'($urandom_range(0, 65535)));
                    write_reg(REG_SONAR_THR,  16'd25);
                    write_reg(REG_RATIO_LOG2, 16'd15);
                end
                1: begin
                    write_reg(REG_MAP_BITS,   16'h0000);
                    write_reg(REG_SONAR_THR,  16'd0);
                    write_reg(REG_RATIO_LOG2, 16'd0);
                end
                2: begin
                    write_reg(REG_MAP_BITS,   16'hFFFF);
                    write_reg(REG_SONAR_THR,  16'd255);
                    write_reg(REG_RATIO_LOG2, 16'd8);
                end
                3: begin
                    write_reg(REG_MAP_BITS,   16'($urandom_range(0, 65535)));
                    write_reg(REG_SONAR_THR,  16'd128);
                    write_reg(REG_RATIO_LOG2, 16'd1);
                end
                4: begin
                    write_reg(REG_MAP_BITS,   16'h5A3C);
                    write_reg(REG_SONAR_THR,  16'd60);
                    write_reg(REG_RATIO_LOG2, 16'd9);
                end
                default: begin
                    write_reg(REG_MAP_BITS,   16'($urandom_range(0, 65535)));
                    write_reg(REG_SONAR_THR,  16'd25);
                    write_reg(REG_RATIO_LOG2, 16'd4);
                end
            endcase

            @(posedge i_clk);
            if (ph < 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 62;
            end else if (ph < 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_random_items(RANDOM_PER_PHASE);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("circular_map_bayes_localizer_unit_test: PASS");
        end else begin
            $display("circular_map_bayes_localizer_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== circular_map_bayes_localizer_unit.f =====
hw/rtl/cbl_pkg.sv
hw/rtl/cbl_in_if.sv
hw/rtl/cbl_out_if.sv
hw/rtl/cbl_cmpsub.sv
hw/rtl/cbl_belief_mem.sv
hw/rtl/circular_map_bayes_localizer_unit.sv
tb/circular_map_bayes_localizer_unit_test.sv
